// File: rtl/core/oct_pkg.sv
// ----------------------------------------------------------------------------
// oct_pkg
// Shared types, field widths and the helper function of the ordered completion
// tracker.
// ----------------------------------------------------------------------------
package oct_pkg;

  localparam int CTX_W     = 2;
  localparam int PEER_W    = 16;
  localparam int SEQ_W     = 16;
  localparam int CODE_W    = 32;
  localparam int CNT_W     = 64;
  localparam int ORD_W     = 32;
  localparam int ERRC_W    = 3;
  localparam int WORD_BITS = 64;
  localparam int OFF_W     = 6;
  localparam int RUN_W     = 7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Per-request update for the context counter and error latches.
  typedef struct packed {
    logic              valid;
    logic [CTX_W-1:0]  ctx;
    logic              failed;
    logic [CODE_W-1:0] code;
    logic [PEER_W-1:0] peer;
    logic [SEQ_W-1:0]  seq;
  } ctx_req_t;

  // Number of consecutive ones starting at bit 0 (64 when all ones).
  function automatic logic [RUN_W-1:0] trailing_ones(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] z;
    logic [WORD_BITS-1:0] iso;
    logic [RUN_W-1:0]     n;
    z   = ~w;
    iso = z & (~z + WORD_BITS'(1));
    n   = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) n = n | RUN_W'(i);
    end
    if (z == '0) n = RUN_W'(WORD_BITS);
    return n;
  endfunction

endpackage

// File: rtl/core/oct_ctx_state.sv
// ----------------------------------------------------------------------------
// oct_ctx_state
// Per-context drain counters, first-error latches and the first failing
// context overall.
// ----------------------------------------------------------------------------
module oct_ctx_state #(
  parameter int CONTEXTS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  oct_pkg::ctx_req_t           req,
  output logic [oct_pkg::CNT_W-1:0]   count_nxt,
  output logic [oct_pkg::ERRC_W-1:0]  first_err
);

  localparam int CI_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;

  logic [oct_pkg::CNT_W-1:0]  count_r    [CONTEXTS];
  logic                       latched_r  [CONTEXTS];
  logic [oct_pkg::CODE_W-1:0] err_code_r [CONTEXTS];
  logic [oct_pkg::PEER_W-1:0] err_peer_r [CONTEXTS];
  logic [oct_pkg::SEQ_W-1:0]  err_seq_r  [CONTEXTS];
  logic [oct_pkg::ERRC_W-1:0] first_err_r;
  logic [CI_W-1:0]            idx;

  assign idx       = CI_W'(req.ctx);
  assign count_nxt = count_r[idx] + oct_pkg::CNT_W'(1);
  assign first_err = first_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CONTEXTS; i++) begin
        count_r[i]    <= '0;
        latched_r[i]  <= 1'b0;
        err_code_r[i] <= '0;
        err_peer_r[i] <= '0;
        err_seq_r[i]  <= '0;
      end
      first_err_r <= '0;
    end else if (req.valid) begin
      count_r[idx] <= count_nxt;
      if (req.failed && !latched_r[idx]) begin
        latched_r[idx]  <= 1'b1;
        err_code_r[idx] <= req.code;
        err_peer_r[idx] <= req.peer;
        err_seq_r[idx]  <= req.seq;
        if (first_err_r == '0) begin
          first_err_r <= oct_pkg::ERRC_W'(req.ctx) + oct_pkg::ERRC_W'(1);
        end
      end
    end
  end

  // Once an error context is recorded it never changes until reset.
  a_first_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(first_err_r) != '0) |-> (first_err_r == $past(first_err_r)))
    else $error("first error context changed after being latched");

  // A failing request always leaves its context latched.
  a_fail_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (req.valid && req.failed) |=> latched_r[$past(idx)])
    else $error("failed request did not latch its context");

  // The first error context is recorded no later than the first failure.
  a_first_err_set: assert property (@(posedge clk) disable iff (!rst_n)
    (req.valid && req.failed) |=> (first_err_r != '0))
    else $error("first error context missing after a failure");

endmodule

// File: rtl/core/ordered_completion_tracker.sv
// ----------------------------------------------------------------------------
// ordered_completion_tracker
// Counts completions per context, latches first errors and advances each
// peer's in-order completion count through a sliding window bitmap.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// in_      in   completion request: context, peer, sequence, error code
// out_     out  drain count, ordered count, flags, first error context
// cfg_     in   peer_count register write
//
// A failed, rejected or dropped request goes from accept straight to the done
// state. A good request passes the set state, then a read and a scan state per
// bitmap word walked (read, then clear and advance), then the done state.
// After reset a clearing pass writes every window word, CONTEXTS*PEERS*
// WINDOW/64 words (4096 by default); no request is taken meanwhile.
// A result waiting in the output register holds the next request in the done
// state, and with it the input.
// ----------------------------------------------------------------------------
module ordered_completion_tracker #(
  parameter int CONTEXTS = 4,
  parameter int PEERS    = 64,
  parameter int WINDOW   = 1024,
  parameter int SEQ_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [6:0]   cfg_wr_data,   // peer_count
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] context_index, [17:2] peer_index, [33:18] sequence_number,
  // [65:34] provider_error, [71:66] zero
  input  logic [71:0]  in_tdata,
  input  logic [0:0]   in_tuser,      // [0] failed
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] context_completed, [95:64] ordered_count,
  // [98:96] error_context_plus_one, [103:99] zero
  output logic [103:0] out_tdata,
  output logic [1:0]   out_tuser      // [0] ordered_valid, [1] peer_rejected
);

  localparam int WPP    = WINDOW / 64;
  localparam int SLOTS  = CONTEXTS * PEERS;
  localparam int WORDS  = SLOTS * WPP;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WIDX_W = (WPP > 1) ? $clog2(WPP) : 1;
  localparam logic [oct_pkg::SEQ_W-1:0] SEQ_MASK = (SEQ_BITS >= oct_pkg::SEQ_W) ?
      {oct_pkg::SEQ_W{1'b1}} : oct_pkg::SEQ_W'((64'd1 << SEQ_BITS) - 64'd1);

  // Input fields.
  logic [oct_pkg::CTX_W-1:0]  in_ctx;
  logic [oct_pkg::PEER_W-1:0] in_peer;
  logic [oct_pkg::SEQ_W-1:0]  in_seq;
  logic [oct_pkg::CODE_W-1:0] in_code;
  logic                       in_failed;
  logic                       in_fire;
  logic                       ctx_ok;
  logic                       peer_bad;
  logic                       good;
  logic [SLOT_W-1:0]          in_slot;
  logic [WIDX_W-1:0]          in_word;
  logic [6:0]                 peer_count_r;

  assign in_ctx    = in_tdata[1:0];
  assign in_peer   = in_tdata[17:2];
  assign in_seq    = in_tdata[33:18] & SEQ_MASK;
  assign in_code   = in_tdata[65:34];
  assign in_failed = in_tuser[0];
  assign in_fire   = in_tvalid && in_tready;
  assign ctx_ok    = 32'(in_ctx) < CONTEXTS;
  assign peer_bad  = (in_peer >= oct_pkg::PEER_W'(peer_count_r)) || (32'(in_peer) >= PEERS);
  assign good      = ctx_ok && !in_failed && !peer_bad;
  assign in_slot   = SLOT_W'(32'(in_ctx) * 32'(PEERS) + 32'(in_peer));
  assign in_word   = WIDX_W'((32'(in_seq) & 32'(WINDOW - 1)) >> 6);

  // State and datapath registers.
  oct_pkg::state_t             state_r, state_nxt;
  logic [WA_W-1:0]             clr_r, clr_nxt;
  logic [SLOT_W-1:0]           slot_r, slot_nxt;
  logic [WIDX_W-1:0]           sword_r, sword_nxt;
  logic [oct_pkg::OFF_W-1:0]   sbit_r, sbit_nxt;
  logic [oct_pkg::ORD_W-1:0]   upto_r, upto_nxt;
  logic [oct_pkg::CNT_W-1:0]   done_cnt_r, done_cnt_nxt;
  logic                        ordv_r, ordv_nxt;
  logic                        rej_r, rej_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [103:0]                out_data_r, out_data_nxt;
  logic [1:0]                  out_user_r, out_user_nxt;

  // Memories.
  logic [oct_pkg::WORD_BITS-1:0] win_mem [WORDS];
  logic [oct_pkg::ORD_W-1:0]     ord_mem [SLOTS];
  logic [oct_pkg::WORD_BITS-1:0] win_rd_r;
  logic [oct_pkg::ORD_W-1:0]     ord_rd_r;
  logic                          win_we;
  logic [WA_W-1:0]               win_waddr, win_raddr;
  logic [oct_pkg::WORD_BITS-1:0] win_wdata;
  logic                          ord_we;
  logic [SLOT_W-1:0]             ord_waddr, ord_raddr;
  logic [oct_pkg::ORD_W-1:0]     ord_wdata;

  // Context counters and error latches.
  oct_pkg::ctx_req_t           ctx_req;
  logic [oct_pkg::CNT_W-1:0]   ctx_count;
  logic [oct_pkg::ERRC_W-1:0]  first_err;

  assign ctx_req.valid  = in_fire && ctx_ok;
  assign ctx_req.ctx    = in_ctx;
  assign ctx_req.failed = in_failed;
  assign ctx_req.code   = in_code;
  assign ctx_req.peer   = in_peer;
  assign ctx_req.seq    = in_seq;

  oct_ctx_state #(.CONTEXTS(CONTEXTS)) u_ctx (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (ctx_req),
    .count_nxt (ctx_count),
    .first_err (first_err)
  );

  // Scan of the word at the current ordered position.
  logic [oct_pkg::OFF_W-1:0]     off;
  logic [oct_pkg::RUN_W-1:0]     run;
  logic [oct_pkg::WORD_BITS-1:0] run_mask;
  logic [oct_pkg::ORD_W-1:0]     upto_adv;
  logic                          run_more;
  logic                          out_free;

  assign off      = upto_r[oct_pkg::OFF_W-1:0];
  assign run      = oct_pkg::trailing_ones(win_rd_r >> off);
  assign run_mask = (run == oct_pkg::RUN_W'(oct_pkg::WORD_BITS)) ? '1 :
                    ((oct_pkg::WORD_BITS'(1) << run) - oct_pkg::WORD_BITS'(1));
  assign upto_adv = upto_r + oct_pkg::ORD_W'(run);
  assign run_more = (run != '0) &&
                    ((oct_pkg::RUN_W'(off) + run) == oct_pkg::RUN_W'(oct_pkg::WORD_BITS));
  assign out_free = !out_valid_r || out_tready;

  function automatic logic [WA_W-1:0] word_addr(input logic [SLOT_W-1:0] s,
                                                input logic [WIDX_W-1:0] w);
    return WA_W'(32'(s) * 32'(WPP) + (32'(w) & 32'(WPP - 1)));
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oct_pkg::ST_CLEAR: if (clr_r == WA_W'(WORDS - 1)) state_nxt = oct_pkg::ST_IDLE;
      oct_pkg::ST_IDLE:  if (in_fire) state_nxt = good ? oct_pkg::ST_SET : oct_pkg::ST_DONE;
      oct_pkg::ST_SET:   state_nxt = oct_pkg::ST_READ;
      oct_pkg::ST_READ:  state_nxt = oct_pkg::ST_SCAN;
      oct_pkg::ST_SCAN:  state_nxt = run_more ? oct_pkg::ST_READ : oct_pkg::ST_DONE;
      oct_pkg::ST_DONE:  if (out_free) state_nxt = oct_pkg::ST_IDLE;
      default:           state_nxt = oct_pkg::ST_CLEAR;
    endcase
  end

  // Outputs, memory ports and datapath updates.
  always_comb begin
    in_tready     = 1'b0;
    clr_nxt       = clr_r;
    slot_nxt      = slot_r;
    sword_nxt     = sword_r;
    sbit_nxt      = sbit_r;
    upto_nxt      = upto_r;
    done_cnt_nxt  = done_cnt_r;
    ordv_nxt      = ordv_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    win_we        = 1'b0;
    win_waddr     = word_addr(slot_r, sword_r);
    win_wdata     = '0;
    win_raddr     = word_addr(slot_r, WIDX_W'(upto_r >> 6));
    ord_we        = 1'b0;
    ord_waddr     = slot_r;
    ord_wdata     = upto_adv;
    ord_raddr     = in_slot;
    case (state_r)
      oct_pkg::ST_CLEAR: begin
        clr_nxt   = clr_r + WA_W'(1);
        win_we    = 1'b1;
        win_waddr = clr_r;
        ord_we    = 32'(clr_r) < SLOTS;
        ord_waddr = SLOT_W'(clr_r);
        ord_wdata = '0;
      end
      oct_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        win_raddr = word_addr(in_slot, in_word);
        if (in_fire) begin
          slot_nxt     = in_slot;
          sword_nxt    = in_word;
          sbit_nxt     = in_seq[oct_pkg::OFF_W-1:0];
          done_cnt_nxt = ctx_ok ? ctx_count : '0;
          ordv_nxt     = good;
          rej_nxt      = ctx_ok && !in_failed && peer_bad;
          upto_nxt     = '0;
        end
      end
      oct_pkg::ST_SET: begin
        win_we    = 1'b1;
        win_wdata = win_rd_r | (oct_pkg::WORD_BITS'(1) << sbit_r);
        upto_nxt  = ord_rd_r;
      end
      oct_pkg::ST_READ: begin
      end
      oct_pkg::ST_SCAN: begin
        win_waddr = word_addr(slot_r, WIDX_W'(upto_r >> 6));
        win_we    = run != '0;
        win_wdata = win_rd_r & ~(run_mask << off);
        upto_nxt  = upto_adv;
        ord_we    = !run_more;
      end
      oct_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, first_err, upto_r, done_cnt_r};
          out_user_nxt  = {rej_r, ordv_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= oct_pkg::ST_CLEAR;
      clr_r        <= '0;
      peer_count_r <= 7'd64;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) peer_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    sword_r    <= sword_nxt;
    sbit_r     <= sbit_nxt;
    upto_r     <= upto_nxt;
    done_cnt_r <= done_cnt_nxt;
    ordv_r     <= ordv_nxt;
    rej_r      <= rej_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_ff @(posedge clk) begin
    if (win_we) win_mem[win_waddr] <= win_wdata;
    win_rd_r <= win_mem[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    ord_rd_r <= ord_mem[ord_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // No request is taken while the memories are being cleared or walked.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (state_r == oct_pkg::ST_IDLE))
    else $error("request accepted outside idle");

  // Failed requests never touch the window.
  a_fail_skips_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_failed) |=> (state_r == oct_pkg::ST_DONE))
    else $error("failed request entered the window walk");

  // A new result is only produced from the done state.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == oct_pkg::ST_DONE))
    else $error("result loaded outside done state");

  // The ordered count is written back exactly when a walk finishes.
  a_ord_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == oct_pkg::ST_SCAN && !run_more) |-> ord_we)
    else $error("ordered count not written back");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives completion requests into the ordered completion tracker and checks
// every result against an in-bench model of drain counts, error latches and
// per-peer window bitmaps, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NCTX      = 4;
  localparam int NPEER     = 64;
  localparam int WIN       = 1024;
  localparam int WPP       = WIN / 64;
  localparam int MAX_CYCLE = 2000000;
  localparam int STALL_LEN = 300;

  typedef struct packed {
    logic [oct_pkg::CTX_W-1:0]  ctx;
    logic [oct_pkg::PEER_W-1:0] peer;
    logic [oct_pkg::SEQ_W-1:0]  seq;
    logic                       failed;
    logic [oct_pkg::CODE_W-1:0] code;
  } completion_t;

  typedef struct packed {
    logic [oct_pkg::CNT_W-1:0]  drained;
    logic [oct_pkg::ORD_W-1:0]  ordered;
    logic                       ord_valid;
    logic                       rejected;
    logic [oct_pkg::ERRC_W-1:0] err_ctx;
  } outcome_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [6:0]   cfg_wr_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;

  ordered_completion_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state.
  logic [63:0]       win_bits [NCTX*NPEER*WPP];
  logic [31:0]       ord_cnt [NCTX*NPEER];
  logic [63:0]       drain_cnt [NCTX];
  logic              err_seen [NCTX];
  logic [2:0]        first_err;
  logic [6:0]        peer_limit;

  completion_t pending_reqs[$];
  outcome_t    expected_outcomes[$];
  int          mismatches = 0;
  int          cycle = 0;
  bit          fast_phase = 0;
  bit          in_taken = 0;
  bit          stall_kick = 0;
  bit          stall_done = 0;
  int          stall_cycles = 0;
  logic        stall_hold;

  assign stall_hold = stall_kick && !stall_done;

  function automatic int ones_run(logic [63:0] w);
    int n;
    n = 0;
    while (n < 64 && w[n]) n++;
    return n;
  endfunction

  function automatic outcome_t predict_completion(completion_t c);
    outcome_t r;
    int slot, pos, off, wi, run;
    logic [31:0] upto;
    r = '0;
    drain_cnt[c.ctx] = drain_cnt[c.ctx] + 64'd1;
    r.drained = drain_cnt[c.ctx];
    if (c.failed) begin
      if (!err_seen[c.ctx]) begin
        err_seen[c.ctx] = 1'b1;
        if (first_err == 0) first_err = 3'(c.ctx) + 3'd1;
      end
    end else if (c.peer >= peer_limit || c.peer >= NPEER) begin
      r.rejected = 1'b1;
    end else begin
      slot = c.ctx * NPEER + c.peer;
      pos = c.seq % WIN;
      win_bits[slot*WPP + pos/64][pos%64] = 1'b1;
      upto = ord_cnt[slot];
      forever begin
        pos = upto % WIN;
        off = pos % 64;
        wi = slot*WPP + pos/64;
        run = ones_run(win_bits[wi] >> off);
        if (run == 0) break;
        for (int i = 0; i < run; i++) win_bits[wi][off+i] = 1'b0;
        upto = upto + 32'(run);
        if (off + run < 64) break;
      end
      ord_cnt[slot] = upto;
      r.ordered = upto;
      r.ord_valid = 1'b1;
    end
    r.err_ctx = first_err;
    return r;
  endfunction

  // Driver: presents pending requests at the falling edge and holds a
  // request steady until it is accepted.
  always @(negedge clk) begin
    if (rst_n) begin
      if (pending_reqs.size() > 0 &&
          ((in_tvalid && !in_taken) || fast_phase || $urandom_range(99) >= 30)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {6'd0, pending_reqs[0].code, pending_reqs[0].seq,
                      pending_reqs[0].peer, pending_reqs[0].ctx};
        in_tuser  <= pending_reqs[0].failed;
      end else begin
        in_tvalid <= 1'b0;
      end
      out_tready <= !stall_hold && (fast_phase || $urandom_range(99) >= 30);
    end
  end

  // Receiver hold-off, counted here once it is started.
  always @(posedge clk) begin
    if (stall_kick && !stall_done) begin
      if (stall_cycles >= STALL_LEN) stall_done <= 1'b1;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // Monitor: records accepted requests and checks accepted results at the
  // rising edge.
  always @(posedge clk) begin
    outcome_t got, exp_r;
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("CHECKS FAILED");
      $finish;
    end
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      expected_outcomes.push_back(predict_completion(pending_reqs.pop_front()));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[63:0], out_tdata[95:64], out_tuser[0], out_tuser[1],
              out_tdata[98:96]};
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_outcomes.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp_r, got);
        end
      end
    end
  end

  task automatic queue_req(int ctx, int peer, int seq, bit failed, logic [31:0] code);
    completion_t c;
    c = '{2'(ctx), 16'(peer), 16'(seq), failed, code};
    pending_reqs.push_back(c);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_peer_limit(logic [6:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    peer_limit = v;
  endtask

  function automatic int ord_cnt_hint(int ctx, int peer);
    return ord_cnt[ctx*NPEER + peer] % 65536;
  endfunction

  // Mostly in-window sequences on a few peers so runs actually advance.
  task automatic queue_random(int n);
    int ctx, peer, seq;
    for (int i = 0; i < n; i++) begin
      ctx = $urandom_range(3);
      if ($urandom_range(9) < 8) begin
        peer = $urandom_range(7);
        seq = ord_cnt_hint(ctx, peer) + $urandom_range(90);
        queue_req(ctx, peer, seq, $urandom_range(19) == 0, $urandom);
      end else begin
        queue_req(ctx, $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(1), $urandom);
      end
    end
  endtask

  initial begin
    foreach (win_bits[i]) win_bits[i] = '0;
    foreach (ord_cnt[i]) ord_cnt[i] = '0;
    for (int i = 0; i < NCTX; i++) begin
      drain_cnt[i] = '0;
      err_seen[i] = 1'b0;
    end
    first_err = '0;
    peer_limit = 7'd64;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, failures, rejects, window wrap.
    queue_req(0, 0, 1, 0, 0);
    queue_req(0, 0, 0, 0, 0);
    queue_req(3, 63, 65535, 0, 32'hFFFFFFFF);
    queue_req(1, 64, 5, 0, 0);
    queue_req(2, 65535, 0, 0, 0);
    queue_req(1, 3, 7, 1, 32'h80000000);
    queue_req(1, 4, 8, 1, 32'h7FFFFFFF);
    queue_req(2, 65535, 65535, 1, 32'hFFFFFFFF);
    for (int s = 0; s < 70; s += 5) queue_req(3, 1, s + 2, 0, 0);
    for (int s = 0; s < 70; s++) if (s % 5 != 2) queue_req(3, 1, s, 0, 0);
    queue_req(0, 2, 1024, 0, 0);
    wait_drained();

    write_peer_limit(7'd1);
    queue_req(0, 0, 2, 0, 0);
    queue_req(0, 1, 0, 0, 0);
    queue_random(150);
    wait_drained();

    write_peer_limit(7'd0);
    queue_random(100);
    wait_drained();

    write_peer_limit(7'd127);
    fast_phase = 1;
    queue_random(400);
    wait_drained();
    fast_phase = 0;

    write_peer_limit(7'd5);
    queue_random(400);
    wait_drained();

    // Long receiver hold-off so the block backs up its input.
    write_peer_limit(7'd64);
    stall_kick = 1;
    queue_random(400);
    wait (stall_done);
    queue_random(400);
    wait_drained();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
